>>> hw/rtl/qlt_pkg.sv
// ----------------------------------------------------------------------------
// qlt_pkg: shared types and constants of the Q-learning table engine
// Payload structs, register codes, fixed-point constants, exp2 root table.
// ----------------------------------------------------------------------------
package qlt_pkg;

	localparam int DEF_STATES  = 1024;
	localparam int DEF_ACTIONS = 8;

	localparam logic signed [15:0] Q_MINUS_ONE = 16'sh8000;
	localparam int                 Q_MAX       = 32767;
	localparam logic [31:0]        ONE_Q30     = 32'h4000_0000;
	localparam logic [31:0]        TWO_LOG2E   = 32'd189097;

	localparam logic [15:0] RST_DISCOUNT = 16'd58982;
	localparam logic [15:0] RST_KEEP     = 16'd52429;
	localparam logic [15:0] RST_LOG2BASE = 16'd4096;
	localparam logic [15:0] RST_EXPLORE  = 16'd0;

	// divider: quotient bits and operand widths
	localparam int DIV_STEPS = 17;
	localparam int NUM_W     = 46;
	localparam int DEN_W     = 31;

	typedef enum logic [1:0] {
		CFG_DISCOUNT = 2'd0,
		CFG_KEEP     = 2'd1,
		CFG_LOG2BASE = 2'd2,
		CFG_EXPLORE  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [9:0]         state_index;
		logic signed [15:0] reward;
		logic [15:0]        random_fraction;
	} item_t;

	typedef struct packed {
		logic [2:0] action;
		logic       explored;
	} result_t;

	typedef struct packed {
		cfg_idx_t    index;
		logic [15:0] value;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_ctl_t;

	typedef struct packed {
		logic                 busy;
		logic [DIV_STEPS-1:0] quotient;
	} div_stat_t;

	// 2^(2^-(b+1)) in Q2.30
	function automatic logic [31:0] exp2_root(input logic [3:0] b);
		logic [31:0] r;
		case (b)
			4'd0:    r = 32'd1518500250;
			4'd1:    r = 32'd1276901417;
			4'd2:    r = 32'd1170923762;
			4'd3:    r = 32'd1121280436;
			4'd4:    r = 32'd1097253708;
			4'd5:    r = 32'd1085434106;
			4'd6:    r = 32'd1079572136;
			4'd7:    r = 32'd1076653033;
			4'd8:    r = 32'd1075196444;
			4'd9:    r = 32'd1074468888;
			4'd10:   r = 32'd1074105295;
			4'd11:   r = 32'd1073923544;
			4'd12:   r = 32'd1073832680;
			4'd13:   r = 32'd1073787251;
			4'd14:   r = 32'd1073764537;
			default: r = 32'd1073753181;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/qlt_chan_if.sv
// ----------------------------------------------------------------------------
// qlt_chan_if: valid/ready channel
// Carries one request of payload type T from source to sink.
// ----------------------------------------------------------------------------
interface qlt_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/qlt_div.sv
// ----------------------------------------------------------------------------
// qlt_div: restoring divider
// One quotient bit per cycle; the quotient must fit in DIV_STEPS bits.
// ----------------------------------------------------------------------------
module qlt_div (
	input  logic               clk,
	input  logic               arst_n,
	input  qlt_pkg::div_ctl_t  ctl,
	output qlt_pkg::div_stat_t stat
);
	localparam int QW = qlt_pkg::DIV_STEPS;
	localparam int DW = qlt_pkg::DEN_W;
	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] quo_q;
	logic [DW:0]   trial;
	logic          ge;

	assign trial = {rem_q, quo_q[QW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			// high part is already below the divisor since the quotient fits
			rem_q <= DW'(ctl.num[qlt_pkg::NUM_W-1:QW]);
			quo_q <= ctl.num[QW-1:0];
			den_q <= ctl.den;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign stat.busy     = busy_q;
	assign stat.quotient = quo_q;
endmodule

>>> hw/rtl/q_learning_table_engine_core.sv
// ----------------------------------------------------------------------------
// q_learning_table_engine_core: tabular Q-learning step engine
// Action selection over one table row and update of the previous entry.
// ----------------------------------------------------------------------------
// Channels: item (state_index, reward, random_fraction) in, result (action,
// explored) out, cfg writes one of four registers by index; cfg is always
// ready. The user must write cfg only while the engine is idle; the core
// does not enforce it. After reset a clearing pass writes -1.0 to all
// STATES*ACTIONS table entries, one per cycle; item.ready stays low until
// the pass ends. Per request: the range fold of the state index, then each
// of the ACTIONS row entries (read, weight multiply, 16 exp2 steps on the
// shared multiplier), selection, the target/tanh path, the bit-serial
// divider and the write-back. One request is in work at a time; the shared
// 32x32 multiplier and the one-bit divider set this.
// The result sits in an output register; a new request is taken while it
// waits, and the engine holds its next result until the old one is taken.
// ----------------------------------------------------------------------------
module q_learning_table_engine_core #(
	parameter int STATES  = qlt_pkg::DEF_STATES,
	parameter int ACTIONS = qlt_pkg::DEF_ACTIONS
) (
	input logic           clk,
	input logic           arst_n,
	qlt_chan_if.sink      item,
	qlt_chan_if.source    result,
	qlt_chan_if.sink      cfg
);
	localparam int DEPTH = STATES * ACTIONS;
	localparam int AW    = $clog2(DEPTH);
	localparam int ACT_W = $clog2(ACTIONS);

	typedef enum logic [22:0] {
		ST_CLEAR = 23'(1) << 0,
		ST_IDLE  = 23'(1) << 1,
		ST_MOD   = 23'(1) << 2,
		ST_RD    = 23'(1) << 3,
		ST_RDW   = 23'(1) << 4,
		ST_WE    = 23'(1) << 5,
		ST_EXP   = 23'(1) << 6,
		ST_EXPA  = 23'(1) << 7,
		ST_SEL   = 23'(1) << 8,
		ST_SELP  = 23'(1) << 9,
		ST_ROUL  = 23'(1) << 10,
		ST_TX    = 23'(1) << 11,
		ST_TX2   = 23'(1) << 12,
		ST_TY    = 23'(1) << 13,
		ST_TY2   = 23'(1) << 14,
		ST_DIVGO = 23'(1) << 15,
		ST_DIVW  = 23'(1) << 16,
		ST_OLD   = 23'(1) << 17,
		ST_OLDW  = 23'(1) << 18,
		ST_UPD1  = 23'(1) << 19,
		ST_UPD2  = 23'(1) << 20,
		ST_OUT   = 23'(1) << 21,
		ST_SPARE = 23'(1) << 22
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0]        discount_q, keep_q, explore_q;
	logic signed [15:0] log2_base_q;

	// per request
	logic [9:0]         s_q;
	logic signed [15:0] rew_q;
	logic [15:0]        p_q;
	logic [ACT_W-1:0]   idx_q;
	logic signed [15:0] best_q;
	logic               has_unv_q;
	logic [ACT_W-1:0]   last_unv_q;
	logic [31:0]        w_q [ACTIONS];
	logic [31:0]        sum_q, cum_q;
	logic [47:0]        psum_q;
	logic [ACT_W-1:0]   act_q;
	logic               explored_q;
	logic signed [17:0] x_q;
	logic [30:0]        e_q;
	logic signed [15:0] t_q;
	logic signed [63:0] v1_q;

	// exp2 iteration
	logic [31:0] acc_q;
	logic [15:0] f_q;
	logic [4:0]  sh_q;
	logic [3:0]  b_q;
	logic        ret_tanh_q;

	// previous step
	logic [9:0]         prev_state_q;
	logic [ACT_W-1:0]   prev_action_q;
	logic signed [15:0] prev_reward_q;

	// memory
	logic [15:0]   mem [DEPTH];
	logic [15:0]   rd_q;
	logic [AW-1:0] rd_addr, wr_addr, clr_q;
	logic          wr_en;
	logic [15:0]   wr_data;

	// shared multiplier
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_q;

	// output register
	logic              res_valid_q;
	qlt_pkg::result_t  res_q;

	qlt_pkg::div_ctl_t  div_ctl;
	qlt_pkg::div_stat_t div_stat;

	qlt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.stat   (div_stat)
	);

	// combinational helpers
	logic [AW-1:0]      row_addr, prev_addr;
	logic signed [63:0] rnd_full, e_full, v_sum, v_rnd;
	logic [31:0]        acc_n;
	logic signed [5:0]  sh_w;
	logic [31:0]        cum_n;
	logic [23:0]        y_w;
	logic [17:0]        a_w;
	logic signed [17:0] x_w;
	logic [16:0]        t_abs;
	logic [31:0]        e_tanh;
	logic [30:0]        den_w;
	logic [45:0]        num_w;
	logic signed [15:0] v_clip;

	assign row_addr  = AW'(32'(s_q) * ACTIONS + 32'(idx_q));
	assign prev_addr = AW'(32'(prev_state_q) * ACTIONS + 32'(prev_action_q));

	assign rnd_full = mul_q + 64'sd536870912;
	assign acc_n    = f_q[4'd15 - b_q] ? rnd_full[61:30] : acc_q;
	assign e_full   = mul_q >>> 11;
	assign sh_w     = 6'sd14 - {e_full[20], e_full[20:16]};
	assign cum_n    = cum_q + w_q[idx_q];
	assign x_w      = 18'(prev_reward_q) + 18'(mul_q >>> 19);
	assign a_w      = x_q[17] ? 18'(-x_q) : 18'(x_q);
	assign y_w      = mul_q[35:12];
	assign e_tanh   = acc_n >> sh_q;
	assign den_w    = 31'(qlt_pkg::ONE_Q30) + e_q;
	assign num_w    = (46'(31'(qlt_pkg::ONE_Q30) - e_q) << 15) + 46'(den_w >> 1);
	assign t_abs    = (div_stat.quotient > 17'(qlt_pkg::Q_MAX)) ?
	                  17'(qlt_pkg::Q_MAX) : div_stat.quotient;
	assign v_sum    = v1_q + mul_q;
	assign v_rnd    = (v_sum + 64'sd32768) >>> 16;

	always_comb begin
		if (v_rnd > 64'sd32767)
			v_clip = 16'sh7fff;
		else if (v_rnd < -64'sd32768)
			v_clip = qlt_pkg::Q_MINUS_ONE;
		else
			v_clip = v_rnd[15:0];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_RDW: begin
				mul_a = 32'(log2_base_q);
				mul_b = 32'(signed'(rd_q));
			end
			ST_EXP: begin
				mul_a = signed'(acc_q);
				mul_b = signed'(qlt_pkg::exp2_root(b_q));
			end
			ST_SEL: begin
				mul_a = signed'({16'd0, p_q});
				mul_b = signed'(sum_q);
			end
			ST_TX: begin
				mul_a = signed'({16'd0, discount_q});
				mul_b = 32'(best_q);
			end
			ST_TY: begin
				mul_a = signed'({14'd0, a_w});
				mul_b = signed'(qlt_pkg::TWO_LOG2E);
			end
			ST_OLDW: begin
				mul_a = signed'({16'd0, keep_q});
				mul_b = 32'(signed'(rd_q));
			end
			ST_UPD1: begin
				mul_a = signed'(32'h0001_0000 - {16'd0, keep_q});
				mul_b = 32'(t_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= 64'(mul_a) * 64'(mul_b);
	end

	assign rd_addr = (state_q == ST_OLD) ? prev_addr : row_addr;
	assign wr_en   = (state_q == ST_CLEAR) || (state_q == ST_UPD2);
	assign wr_addr = (state_q == ST_CLEAR) ? clr_q : prev_addr;
	assign wr_data = (state_q == ST_CLEAR) ? qlt_pkg::Q_MINUS_ONE : v_clip;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	assign div_ctl.start = (state_q == ST_DIVGO);
	assign div_ctl.num   = num_w;
	assign div_ctl.den   = den_w;

	// configuration port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discount_q  <= qlt_pkg::RST_DISCOUNT;
			keep_q      <= qlt_pkg::RST_KEEP;
			log2_base_q <= signed'(qlt_pkg::RST_LOG2BASE);
			explore_q   <= qlt_pkg::RST_EXPLORE;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				qlt_pkg::CFG_DISCOUNT: discount_q  <= cfg.data.value;
				qlt_pkg::CFG_KEEP:     keep_q      <= cfg.data.value;
				qlt_pkg::CFG_LOG2BASE: log2_base_q <= signed'(cfg.data.value);
				qlt_pkg::CFG_EXPLORE:  explore_q   <= cfg.data.value;
				default: ;
			endcase
		end
	end

	assign item.ready = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			prev_state_q  <= '0;
			prev_action_q <= '0;
			prev_reward_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (item.valid)
						state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (32'(s_q) < STATES)
						state_q <= ST_RD;
				end
				ST_RD:   state_q <= ST_RDW;
				ST_RDW:  state_q <= ST_WE;
				ST_WE:   state_q <= ST_EXP;
				ST_EXP:  state_q <= ST_EXPA;
				ST_EXPA: begin
					if (b_q != 4'd15)
						state_q <= ST_EXP;
					else if (ret_tanh_q)
						state_q <= ST_DIVGO;
					else if (idx_q == ACT_W'(ACTIONS - 1))
						state_q <= ST_SEL;
					else
						state_q <= ST_RD;
				end
				ST_SEL: begin
					if (has_unv_q && (p_q < explore_q))
						state_q <= ST_TX;
					else
						state_q <= ST_SELP;
				end
				ST_SELP: state_q <= ST_ROUL;
				ST_ROUL: begin
					if ((psum_q < {cum_n, 16'd0}) || (idx_q == ACT_W'(ACTIONS - 1)))
						state_q <= ST_TX;
				end
				ST_TX:  state_q <= ST_TX2;
				ST_TX2: state_q <= ST_TY;
				ST_TY:  state_q <= ST_TY2;
				ST_TY2: begin
					if ((y_w[15:0] == 16'd0) || (y_w[23:16] >= 8'd30))
						state_q <= ST_DIVGO;
					else
						state_q <= ST_EXP;
				end
				ST_DIVGO: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (!div_stat.busy)
						state_q <= ST_OLD;
				end
				ST_OLD:  state_q <= ST_OLDW;
				ST_OLDW: state_q <= ST_UPD1;
				ST_UPD1: state_q <= ST_UPD2;
				ST_UPD2: begin
					prev_state_q  <= s_q;
					prev_action_q <= act_q;
					prev_reward_q <= rew_q;
					state_q       <= ST_OUT;
				end
				ST_OUT: begin
					if (!res_valid_q || result.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				s_q   <= item.data.state_index;
				rew_q <= item.data.reward;
				p_q   <= item.data.random_fraction;
				idx_q <= '0;
				sum_q <= '0;
			end
			ST_MOD: begin
				if (32'(s_q) >= STATES)
					s_q <= s_q - 10'(STATES);
			end
			ST_RDW: begin
				if (idx_q == '0) begin
					best_q    <= signed'(rd_q);
					has_unv_q <= (signed'(rd_q) == qlt_pkg::Q_MINUS_ONE);
					last_unv_q <= '0;
				end else begin
					if (signed'(rd_q) > best_q)
						best_q <= signed'(rd_q);
					if (signed'(rd_q) == qlt_pkg::Q_MINUS_ONE) begin
						has_unv_q  <= 1'b1;
						last_unv_q <= idx_q;
					end
				end
			end
			ST_WE: begin
				f_q        <= e_full[15:0];
				sh_q       <= 5'(sh_w);
				acc_q      <= qlt_pkg::ONE_Q30;
				b_q        <= '0;
				ret_tanh_q <= 1'b0;
			end
			ST_EXPA: begin
				acc_q <= acc_n;
				b_q   <= b_q + 1'b1;
				if (b_q == 4'd15) begin
					if (ret_tanh_q) begin
						e_q <= e_tanh[30:0];
					end else begin
						w_q[idx_q] <= e_tanh;
						sum_q      <= sum_q + e_tanh;
						if (idx_q != ACT_W'(ACTIONS - 1))
							idx_q <= idx_q + 1'b1;
					end
				end
			end
			ST_SEL: begin
				act_q      <= last_unv_q;
				explored_q <= has_unv_q && (p_q < explore_q);
			end
			ST_SELP: begin
				psum_q <= mul_q[47:0];
				idx_q  <= '0;
				cum_q  <= '0;
			end
			ST_ROUL: begin
				cum_q <= cum_n;
				idx_q <= idx_q + 1'b1;
				if (psum_q < {cum_n, 16'd0})
					act_q <= idx_q;
				else if (idx_q == ACT_W'(ACTIONS - 1))
					act_q <= '0;
			end
			ST_TX2: x_q <= x_w;
			ST_TY2: begin
				f_q        <= 16'(17'h10000 - {1'b0, y_w[15:0]});
				sh_q       <= 5'(y_w[23:16] + 8'd1);
				acc_q      <= qlt_pkg::ONE_Q30;
				b_q        <= '0;
				ret_tanh_q <= 1'b1;
				if (y_w[15:0] == 16'd0)
					e_q <= (y_w[23:16] >= 8'd31) ? 31'd0 :
					       31'(qlt_pkg::ONE_Q30 >> y_w[23:16]);
				else if (y_w[23:16] >= 8'd30)
					e_q <= 31'd0;
			end
			ST_DIVW: t_q <= x_q[17] ? -signed'(16'(t_abs)) : signed'(16'(t_abs));
			ST_UPD1: v1_q <= mul_q;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if ((state_q == ST_OUT) && (!res_valid_q || result.ready))
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && (!res_valid_q || result.ready)) begin
			res_q.action   <= 3'(act_q);
			res_q.explored <= explored_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;
endmodule

>>> sim/tb_q_learning_table_engine_core.sv
// ----------------------------------------------------------------------------
// tb_q_learning_table_engine_core: self-checking bench of the Q-learning core
// Drives state/reward/random requests, predicts action and explored from a
// local copy of the table and registers, checks results in order.
// ----------------------------------------------------------------------------
module tb_q_learning_table_engine_core;

	localparam int NS = qlt_pkg::DEF_STATES;
	localparam int NA = qlt_pkg::DEF_ACTIONS;

	logic clk;
	logic arst_n;

	qlt_chan_if #(.T(qlt_pkg::item_t))   item_ch ();
	qlt_chan_if #(.T(qlt_pkg::result_t)) res_ch ();
	qlt_chan_if #(.T(qlt_pkg::cfg_t))    cfg_ch ();

	q_learning_table_engine_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// predictor state
	logic signed [15:0] tbl [NS*NA];
	int unsigned        last_state, last_action;
	int                 last_reward;
	int unsigned        gamma_r, alpha_r, explore_r;
	int                 log2k_r;

	qlt_pkg::item_t   pending_items [$];
	qlt_pkg::result_t want_results [$];
	int               errors;
	int               send_idle, recv_idle;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void add_item(qlt_pkg::item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic void add_want(qlt_pkg::result_t r);
		want_results.insert(want_results.size(), r);
	endfunction

	function automatic longint fshift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint unsigned pow2_frac(int unsigned f);
		longint unsigned acc;
		acc = 64'd1 << 30;
		for (int b = 0; b < 16; b++)
			if ((f >> (15 - b)) & 1)
				acc = (acc * longint'(qlt_pkg::exp2_root(b[3:0])) + (64'd1 << 29)) >> 30;
		return acc;
	endfunction

	function automatic longint unsigned weight_q16(int q);
		longint e, i;
		e = fshift(longint'(log2k_r) * q, 11);
		i = fshift(e, 16);
		return pow2_frac(32'(e & 64'hFFFF)) >> (14 - i);
	endfunction

	function automatic int tanh_q15(longint x);
		longint unsigned a, y, n, r, e, num, den, t;
		a = (x < 0) ? -x : x;
		y = (a * 189097) >> 12;
		n = y >> 16;
		r = y & 64'hFFFF;
		if (r == 0) e = (n >= 31) ? 64'd0 : ((64'd1 << 30) >> n);
		else e = (n + 1 >= 31) ? 64'd0 : (pow2_frac(32'(65536 - r)) >> (n + 1));
		num = ((64'd1 << 30) - e) << 15;
		den = (64'd1 << 30) + e;
		t = (num + den / 2) / den;
		if (t > 64'(qlt_pkg::Q_MAX)) t = 64'(qlt_pkg::Q_MAX);
		return (x < 0) ? -int'(t) : int'(t);
	endfunction

	function automatic qlt_pkg::result_t learn_step(qlt_pkg::item_t it);
		qlt_pkg::result_t res;
		int unsigned s, p, act, last_unv, best, pidx;
		logic has_unv;
		int row [NA];
		longint unsigned sum, cum;
		longint x, v;
		int t, old;
		s = it.state_index % NS;
		p = 32'(it.random_fraction);
		sum = 0; cum = 0; act = 0; last_unv = 0; best = 0; has_unv = 1'b0;
		for (int a = 0; a < NA; a++) begin
			row[a] = int'(tbl[s*NA + a]);
			sum += weight_q16(row[a]);
			if (row[a] == -32768) begin
				has_unv = 1'b1;
				last_unv = a;
			end
			if (row[a] > row[best]) best = a;
		end
		res.explored = 1'b0;
		if (has_unv && p < explore_r) begin
			act = last_unv;
			res.explored = 1'b1;
		end else begin
			for (int a = 0; a < NA; a++) begin
				cum += weight_q16(row[a]);
				if (longint'(p) * sum < (cum << 16)) begin
					act = a;
					break;
				end
			end
		end
		x = longint'(last_reward) + fshift(longint'(gamma_r) * row[best], 19);
		t = tanh_q15(x);
		pidx = (last_state % NS) * NA + (last_action % NA);
		old = int'(tbl[pidx]);
		v = longint'(alpha_r) * old + longint'(65536 - alpha_r) * t;
		v = fshift(v + 32768, 16);
		if (v > qlt_pkg::Q_MAX) v = qlt_pkg::Q_MAX;
		if (v < -32768) v = -32768;
		tbl[pidx] = v[15:0];
		last_state = s;
		last_action = act;
		last_reward = int'(it.reward);
		res.action = act[2:0];
		return res;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.data  <= '0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
				item_ch.valid <= 1'b1;
				item_ch.data  <= pending_items.pop_front();
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// prediction on accept, result check
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				add_want(learn_step(item_ch.data));
			if (res_ch.valid && res_ch.ready) begin
				if (want_results.size() == 0) begin
					$error("unexpected result action=%0d", res_ch.data.action);
					errors++;
				end else begin
					qlt_pkg::result_t w;
					w = want_results.pop_front();
					if (w.action !== res_ch.data.action) begin
						$error("action expected %0d actual %0d", w.action,
							res_ch.data.action);
						errors++;
					end
					if (w.explored !== res_ch.data.explored) begin
						$error("explored expected %0d actual %0d", w.explored,
							res_ch.data.explored);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_ch.ready <= 1'b0;
		else res_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	// valid stays high across back-to-back writes; end_writes drops it
	task automatic write_reg(qlt_pkg::cfg_idx_t idx, logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{index: idx, value: val};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			qlt_pkg::CFG_DISCOUNT: gamma_r   = 32'(val);
			qlt_pkg::CFG_KEEP:     alpha_r   = 32'(val);
			qlt_pkg::CFG_LOG2BASE: log2k_r   = int'($signed(val));
			qlt_pkg::CFG_EXPLORE:  explore_r = 32'(val);
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || item_ch.valid || want_results.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic qlt_pkg::item_t rand_item(int hot);
		qlt_pkg::item_t it;
		it.state_index     = hot ? 10'($urandom_range(15)) : 10'($urandom_range(1023));
		it.reward          = 16'($urandom);
		it.random_fraction = 16'($urandom);
		return it;
	endfunction

	task automatic queue_items(int n);
		for (int k = 0; k < n; k++)
			add_item(rand_item(int'($urandom_range(99) < 80)));
	endtask

	initial begin
		qlt_pkg::item_t it;
		errors = 0;
		send_idle = 16;
		recv_idle = 77;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		for (int k = 0; k < NS*NA; k++) tbl[k] = qlt_pkg::Q_MINUS_ONE;
		last_state = 0; last_action = 0; last_reward = 0;
		gamma_r = 32'(qlt_pkg::RST_DISCOUNT); alpha_r = 32'(qlt_pkg::RST_KEEP);
		log2k_r = int'($signed(qlt_pkg::RST_LOG2BASE));
		explore_r = 32'(qlt_pkg::RST_EXPLORE);
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, field extremes, same-row repeats
		add_item('{state_index: 10'd0, reward: 16'sh7FFF,
			random_fraction: 16'h0000});
		add_item('{state_index: 10'd0, reward: 16'sh8000,
			random_fraction: 16'hFFFF});
		add_item('{state_index: 10'd1023, reward: 16'sh0000,
			random_fraction: 16'h8000});
		add_item('{state_index: 10'd1023, reward: 16'sh7FFF,
			random_fraction: 16'hFFFF});
		drain();
		// exploration on, extreme gains
		write_reg(qlt_pkg::CFG_EXPLORE, 16'hFFFF);
		write_reg(qlt_pkg::CFG_DISCOUNT, 16'hFFFF);
		write_reg(qlt_pkg::CFG_KEEP, 16'h0000);
		write_reg(qlt_pkg::CFG_LOG2BASE, 16'h7FFF);
		end_writes();
		for (int k = 0; k < 10; k++) begin
			it = rand_item(1);
			it.state_index = 10'd5;
			add_item(it);
		end
		drain();
		write_reg(qlt_pkg::CFG_DISCOUNT, 16'h0000);
		write_reg(qlt_pkg::CFG_KEEP, 16'hFFFF);
		write_reg(qlt_pkg::CFG_LOG2BASE, 16'h8000);
		write_reg(qlt_pkg::CFG_EXPLORE, 16'h0000);
		end_writes();
		for (int k = 0; k < 8; k++) add_item(rand_item(1));
		drain();

		// random phases
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin send_idle = 77; recv_idle = 16; end
			if (ph == 4) begin send_idle = 0; recv_idle = 0; end
			write_reg(qlt_pkg::CFG_DISCOUNT, 16'($urandom));
			write_reg(qlt_pkg::CFG_KEEP, 16'($urandom));
			write_reg(qlt_pkg::CFG_LOG2BASE, (ph == 1) ? 16'h0000 : 16'($urandom));
			write_reg(qlt_pkg::CFG_EXPLORE, (ph == 3) ? 16'h0000 : 16'($urandom));
			end_writes();
			queue_items(120);
			drain();
		end
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#400_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> q_learning_table_engine_core.f
hw/rtl/qlt_pkg.sv
hw/rtl/qlt_chan_if.sv
hw/rtl/qlt_div.sv
hw/rtl/q_learning_table_engine_core.sv
sim/tb_q_learning_table_engine_core.sv
